/* rtl/lnvar_pkg.sv */
// Shared types, widths and codes for the layer-norm row variance block.
`default_nettype none
package lnvar_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 11;
  localparam int SUM_W    = 27;
  localparam int SQ_W     = 41;
  localparam int EPS_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int OUT_W    = 48;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  // Back-end arithmetic widths
  localparam int MEANSQ_W = 2 * SUM_W;
  localparam int TOTAL_W  = SQ_W + 1;
  localparam int PROD_W   = TOTAL_W + GAIN_W;
  localparam int FRAC_SH  = 12;
  localparam int STEP_W   = $clog2(SQ_W);

  // Row length limit and queue size
  localparam int MAX_ROW_LENGTH_DEF = 1024;
  localparam int QUEUE_DEPTH        = 2;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_ROW_LENGTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_EPS_VALUE     = 2'd1;
  localparam logic [IDX_W-1:0] REG_VARIANCE_GAIN = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]  ROW_LENGTH_RST    = 11'd1024;
  localparam logic [EPS_W-1:0]  EPS_VALUE_RST     = 32'd0;
  localparam logic [GAIN_W-1:0] VARIANCE_GAIN_RST = 16'd4096;

  // One finished row handed from the front end to the back end
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [LEN_W-1:0]        len;
  } row_stats_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SQUARE,
    BK_SUM,
    BK_PRODUCT,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/lnvar_front.sv */
// Front end: takes samples, accumulates sum and sum of squares, closes rows.
`default_nettype none
module lnvar_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [lnvar_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample
  input  wire logic [lnvar_pkg::LEN_W-1:0]         eff_len,
  input  wire lnvar_pkg::q_status_t                q_stat,
  output logic                                     push,
  output lnvar_pkg::row_stats_t                    push_row
);
  import lnvar_pkg::*;

  logic [LEN_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;

  logic                    accept;
  logic [LEN_W-1:0]        count_next;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]         sumsq_next;
  logic signed [2*SAMPLE_W-1:0] square;
  logic                    row_end;

  // A row end may need a queue slot, so hold off whenever the queue is full
  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Accumulate the incoming sample
  always_comb begin
    square     = $signed(s_axis_tdata) * $signed(s_axis_tdata);
    count_next = count + LEN_W'(1);
    sum_next   = sum + SUM_W'($signed(s_axis_tdata));
    sumsq_next = sumsq + SQ_W'(square[2*SAMPLE_W-2:0]);
    row_end    = count_next >= eff_len;
  end

  assign push           = accept && row_end;
  assign push_row.sum   = sum_next;
  assign push_row.sumsq = sumsq_next;
  assign push_row.len   = eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else if (accept) begin
      if (row_end) begin
        count <= '0;
        sum   <= '0;
        sumsq <= '0;
      end else begin
        count <= count_next;
        sum   <= sum_next;
        sumsq <= sumsq_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/lnvar_queue.sv */
// Short first-in first-out queue of finished rows between front and back end.
`default_nettype none
module lnvar_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lnvar_pkg::row_stats_t push_row,
  input  wire logic                  pop,
  output lnvar_pkg::row_stats_t      head_row,
  output lnvar_pkg::q_status_t       q_stat
);
  import lnvar_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  row_stats_t      slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  // Pointer advance with wrap at the queue depth
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + AW'(1);
    return r;
  endfunction

  assign head_row     = slots[rd_ptr];
  assign q_stat.full  = fill == CW'(QUEUE_DEPTH);
  assign q_stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

endmodule
`default_nettype wire

/* rtl/lnvar_back.sv */
// Back end: divides the row sums, forms the variance, scales it and emits it.
`default_nettype none
module lnvar_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lnvar_pkg::row_stats_t           head_row,
  input  wire lnvar_pkg::q_status_t            q_stat,
  output logic                                 pop,
  input  wire logic [lnvar_pkg::EPS_W-1:0]     eps_value,
  input  wire logic [lnvar_pkg::GAIN_W-1:0]    variance_gain,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [lnvar_pkg::OUT_W-1:0]          m_axis_tdata  // [47:0] scaled_variance
);
  import lnvar_pkg::*;

  back_state_t state, state_next;

  logic [LEN_W-1:0]    divisor;
  logic [SQ_W-1:0]     sq_work;
  logic [SQ_W-1:0]     mn_work;
  logic [LEN_W-1:0]    sq_rem;
  logic [LEN_W-1:0]    mn_rem;
  logic [STEP_W-1:0]   step;
  logic [MEANSQ_W-1:0] mean_sq;
  logic [TOTAL_W-1:0]  total;
  logic [PROD_W-1:0]   prod;

  logic                load, div_en, sq_en, sum_en, prod_en, emit;
  logic [SUM_W-1:0]    sum_mag;
  logic [LEN_W:0]      sq_trial, mn_trial;
  logic                sq_ge, mn_ge;
  logic [MEANSQ_W-1:0] msq_ext;
  logic [MEANSQ_W-1:0] var_full;

  // Sequencer: state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state and step enables
  always_comb begin
    state_next = state;
    load    = 1'b0;
    div_en  = 1'b0;
    sq_en   = 1'b0;
    sum_en  = 1'b0;
    prod_en = 1'b0;
    emit    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          load       = 1'b1;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        div_en = 1'b1;
        if (step == STEP_W'(SQ_W - 1)) state_next = BK_SQUARE;
      end
      BK_SQUARE: begin
        sq_en      = 1'b1;
        state_next = BK_SUM;
      end
      BK_SUM: begin
        sum_en     = 1'b1;
        state_next = BK_PRODUCT;
      end
      BK_PRODUCT: begin
        prod_en    = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign pop = load;

  // Magnitude of the row sum; its square does not depend on the sign
  assign sum_mag = head_row.sum[SUM_W-1] ? SUM_W'(-head_row.sum) : SUM_W'(head_row.sum);

  // One restoring division step on each dividend, quotient bits shift in from the right
  always_comb begin
    sq_trial = {sq_rem, sq_work[SQ_W-1]};
    mn_trial = {mn_rem, mn_work[SQ_W-1]};
    sq_ge    = sq_trial >= {1'b0, divisor};
    mn_ge    = mn_trial >= {1'b0, divisor};
  end

  // Variance, clamped at zero
  always_comb begin
    msq_ext  = MEANSQ_W'(sq_work);
    var_full = (msq_ext > mean_sq) ? (msq_ext - mean_sq) : '0;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load) begin
      divisor <= head_row.len;
      sq_work <= head_row.sumsq;
      mn_work <= SQ_W'(sum_mag);
      sq_rem  <= '0;
      mn_rem  <= '0;
      step    <= '0;
    end else if (div_en) begin
      sq_work <= {sq_work[SQ_W-2:0], sq_ge};
      mn_work <= {mn_work[SQ_W-2:0], mn_ge};
      sq_rem  <= sq_ge ? LEN_W'(sq_trial - {1'b0, divisor}) : LEN_W'(sq_trial);
      mn_rem  <= mn_ge ? LEN_W'(mn_trial - {1'b0, divisor}) : LEN_W'(mn_trial);
      step    <= step + STEP_W'(1);
    end
    if (sq_en) begin
      mean_sq <= mn_work[SUM_W-1:0] * mn_work[SUM_W-1:0];
    end
    if (sum_en) begin
      total <= TOTAL_W'(var_full[SQ_W-1:0]) + TOTAL_W'(eps_value);
    end
    if (prod_en) begin
      prod <= total * variance_gain;
    end
  end

  // Output register; the shifted product is narrower than the field, so it never saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= OUT_W'(prod[PROD_W-1:FRAC_SH]);
    end
  end

endmodule
`default_nettype wire

/* rtl/layernorm_row_variance_stats.sv */
// Top level of the layer-norm row variance block: config registers, front, queue, back.
//
// Samples (signed Q4.12) arrive on the s_axis channel, one per transfer, and are
// grouped into rows of row_length samples (0 acts as 1, values above
// MAX_ROW_LENGTH act as MAX_ROW_LENGTH). For each completed row one result,
// (variance + eps_value) * variance_gain as unsigned Q24.24, leaves on m_axis.
// The front end takes one sample per cycle while the queue has a free slot.
// A finished row goes into a two-entry queue; the back end runs a one-bit-per-
// cycle restoring divider for the mean and the mean square, then separate
// steps for the square of the mean, the epsilon add and the gain multiply. The
// back end takes a new row only after it has moved the result of the last row
// into the output register. Long rows stream at one sample per cycle while the
// queue has a free slot; short rows are limited by the divider loop.
// When m_axis is stalled, the result holds in the output register, the back end
// waits, the queue fills and s_axis_tready drops once both slots are taken.
// Reset (rst, synchronous) clears the accumulators, the queue and the output
// valid, and restores the register defaults. Config writes belong in periods
// when no row result is in flight.
`default_nettype none
module layernorm_row_variance_stats #(
  parameter int MAX_ROW_LENGTH = lnvar_pkg::MAX_ROW_LENGTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [lnvar_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [lnvar_pkg::OUT_W-1:0]            m_axis_tdata,  // [47:0] scaled_variance
  input  wire logic                              cfg_wr_en,
  input  wire logic [lnvar_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [lnvar_pkg::CFG_W-1:0]       cfg_data
);
  import lnvar_pkg::*;

  // Largest length the 11-bit register can ask for, bounded by the parameter
  localparam int          MaxLenInt = (MAX_ROW_LENGTH > 2047) ? 2047 : MAX_ROW_LENGTH;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MaxLenInt);

  logic [LEN_W-1:0]  row_length;
  logic [EPS_W-1:0]  eps_value;
  logic [GAIN_W-1:0] variance_gain;
  logic [LEN_W-1:0]  eff_len;

  logic       push, pop;
  row_stats_t push_row, head_row;
  q_status_t  q_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= ROW_LENGTH_RST;
      eps_value     <= EPS_VALUE_RST;
      variance_gain <= VARIANCE_GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_LENGTH:    row_length    <= cfg_data[LEN_W-1:0];
        REG_EPS_VALUE:     eps_value     <= cfg_data[EPS_W-1:0];
        REG_VARIANCE_GAIN: variance_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row length
  always_comb begin
    if (row_length == '0)         eff_len = LEN_W'(1);
    else if (row_length > MAX_LEN) eff_len = MAX_LEN;
    else                          eff_len = row_length;
  end

  lnvar_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .eff_len       (eff_len),
    .q_stat        (q_stat),
    .push          (push),
    .push_row      (push_row)
  );

  lnvar_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_row (push_row),
    .pop      (pop),
    .head_row (head_row),
    .q_stat   (q_stat)
  );

  lnvar_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_row      (head_row),
    .q_stat        (q_stat),
    .pop           (pop),
    .eps_value     (eps_value),
    .variance_gain (variance_gain),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Queue never reports full and empty together
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // A finished row is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("row pushed into full queue");

  // The back end only takes a row that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("row popped from empty queue");

  // No result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

/* tb/layernorm_row_variance_stats_tb.sv */
// Self-checking testbench for the layer-norm row variance block.
`timescale 1ns / 1ps
module layernorm_row_variance_stats_tb;

  localparam int ROW_MAX     = lnvar_pkg::MAX_ROW_LENGTH_DEF;
  localparam int SETTLE      = 64;   // quiet time after the last result
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int TOTAL_ITEMS = 1300;
  localparam logic [lnvar_pkg::IDX_W-1:0] REG_SPARE = 2'd3;  // not a register

  typedef enum bit {STEP_WRITE, STEP_SAMPLE} step_kind_t;

  typedef struct {
    step_kind_t                    kind;
    logic [lnvar_pkg::IDX_W-1:0]   idx;
    logic [lnvar_pkg::CFG_W-1:0]   data;
    bit                            has_typed;
    logic [lnvar_pkg::OUT_W-1:0]   typed;
  } step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lnvar_pkg::SAMPLE_W-1:0]  s_axis_tdata = '0;   // [15:0] sample
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lnvar_pkg::OUT_W-1:0]     m_axis_tdata;        // [47:0] scaled_variance
  logic                            cfg_wr_en = 1'b0;
  logic [lnvar_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [lnvar_pkg::CFG_W-1:0]     cfg_data = '0;

  // Row statistics mirror: registers and accumulators
  logic [lnvar_pkg::LEN_W-1:0]     len_reg;
  logic [lnvar_pkg::EPS_W-1:0]     eps_reg;
  logic [lnvar_pkg::GAIN_W-1:0]    gain_reg;
  int                              acc_count;
  longint                          acc_sum;
  logic [63:0]                     acc_sumsq;

  logic [lnvar_pkg::OUT_W-1:0]     variance_q[$];
  logic [lnvar_pkg::OUT_W-1:0]     want;
  step_t                           directed[$];
  int                              mismatches = 0;
  int                              samples_sent = 0;
  int                              burst_left = 0;
  bit                              gaps_on = 1'b1;
  bit                              hold_off_req = 1'b0;

  layernorm_row_variance_stats i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Row length after the zero and upper-limit rules
  function automatic int effective_len();
    int n;
    n = int'(len_reg);
    if (n == 0) n = 1;
    if (n > ROW_MAX) n = ROW_MAX;
    return n;
  endfunction

  // (max(msq - mean^2, 0) + eps) * gain >> 12, saturated to 48 bits
  function automatic logic [lnvar_pkg::OUT_W-1:0] row_variance(input int n);
    longint      mean;
    logic [63:0] mag;
    logic [63:0] msq;
    logic [63:0] mean_sq;
    logic [63:0] spread;
    logic [63:0] prod;
    mean    = acc_sum / longint'(n);
    msq     = acc_sumsq / 64'(n);
    mag     = (mean < 0) ? 64'(-mean) : 64'(mean);
    mean_sq = mag * mag;
    spread  = (msq > mean_sq) ? msq - mean_sq : 64'd0;
    prod    = ((spread + 64'(eps_reg)) * 64'(gain_reg)) >> lnvar_pkg::FRAC_SH;
    if (prod > 64'hFFFF_FFFF_FFFF) prod = 64'hFFFF_FFFF_FFFF;
    return prod[lnvar_pkg::OUT_W-1:0];
  endfunction

  function automatic void apply_register(input logic [lnvar_pkg::IDX_W-1:0] idx,
                                         input logic [lnvar_pkg::CFG_W-1:0] data);
    case (idx)
      lnvar_pkg::REG_ROW_LENGTH:    len_reg  = data[lnvar_pkg::LEN_W-1:0];
      lnvar_pkg::REG_EPS_VALUE:     eps_reg  = data[lnvar_pkg::EPS_W-1:0];
      lnvar_pkg::REG_VARIANCE_GAIN: gain_reg = data[lnvar_pkg::GAIN_W-1:0];
      default: ;  // write to a missing register is dropped
    endcase
  endfunction

  // Accumulate one accepted sample; queue the row result when the row closes
  function automatic void take_sample(input logic [lnvar_pkg::SAMPLE_W-1:0] raw,
                                      input bit has_typed,
                                      input logic [lnvar_pkg::OUT_W-1:0] typed);
    longint                      s;
    logic [63:0]                 mag;
    int                          n;
    logic [lnvar_pkg::OUT_W-1:0] result;
    s   = longint'($signed(raw));
    mag = (s < 0) ? 64'(-s) : 64'(s);
    n   = effective_len();
    acc_sum   = acc_sum + s;
    acc_sumsq = acc_sumsq + mag * mag;
    acc_count = acc_count + 1;
    if (acc_count >= n) begin
      result = has_typed ? typed : row_variance(n);
      variance_q.push_back(result);
      acc_count = 0;
      acc_sum   = 0;
      acc_sumsq = '0;
    end
  endfunction

  // Wait until every row result is out and the back end has gone quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (variance_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [lnvar_pkg::IDX_W-1:0] idx,
                                input logic [lnvar_pkg::CFG_W-1:0] data);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_register(idx, data);
  endtask

  // Offer one sample in the current burst; gaps open between bursts while gaps are on
  task automatic offer(input logic [lnvar_pkg::SAMPLE_W-1:0] v, input bit has_typed,
                       input logic [lnvar_pkg::OUT_W-1:0] typed);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    take_sample(v, has_typed, typed);
    samples_sent = samples_sent + 1;
  endtask

  // Length plus a random mix of the other registers for one phase
  task automatic set_phase_registers(input int len);
    logic [20:0] junk;
    junk = $urandom_range(0, 1) ? 21'($urandom) : 21'd0;
    write_register(lnvar_pkg::REG_ROW_LENGTH, {junk, 11'(len)});
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       write_register(lnvar_pkg::REG_EPS_VALUE, 32'd0);
        1:       write_register(lnvar_pkg::REG_EPS_VALUE, 32'hFFFF_FFFF);
        2:       write_register(lnvar_pkg::REG_EPS_VALUE, $urandom);
        default: write_register(lnvar_pkg::REG_EPS_VALUE, $urandom_range(0, 1 << 20));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       write_register(lnvar_pkg::REG_VARIANCE_GAIN, {16'($urandom), 16'd0});
        1:       write_register(lnvar_pkg::REG_VARIANCE_GAIN, 32'h0000_FFFF);
        2:       write_register(lnvar_pkg::REG_VARIANCE_GAIN, 32'h0000_1000);
        default: write_register(lnvar_pkg::REG_VARIANCE_GAIN, $urandom);
      endcase
    end
    if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, $urandom);
  endtask

  // Sample flavors: full range, extremes, clustered around a base, constant
  function automatic logic [lnvar_pkg::SAMPLE_W-1:0] pick_sample(
      input int style, input logic [lnvar_pkg::SAMPLE_W-1:0] base);
    case (style)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: return base + 16'($urandom_range(0, 255)) - 16'd128;
      default: return base;
    endcase
  endfunction

  // Phase of random samples in one style
  task automatic send_samples(input int count);
    int                            style;
    logic [lnvar_pkg::SAMPLE_W-1:0] base;
    style   = $urandom_range(0, 3);
    base    = 16'($urandom);
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (count) offer(pick_sample(style, base), 1'b0, '0);
  endtask

  function automatic void add_step(input step_kind_t kind,
                                   input logic [lnvar_pkg::IDX_W-1:0] idx,
                                   input logic [lnvar_pkg::CFG_W-1:0] data,
                                   input bit has_typed,
                                   input logic [lnvar_pkg::OUT_W-1:0] typed);
    step_t st;
    st.kind      = kind;
    st.idx       = idx;
    st.data      = data;
    st.has_typed = has_typed;
    st.typed     = typed;
    directed.push_back(st);
  endfunction

  // Receiver: segments of varying readiness, plus one long hold-off on request
  initial begin
    int seg_left;
    int ready_pct;
    seg_left  = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      seg_left = seg_left - 1;
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Result check on every output transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (variance_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, m_axis_tdata);
        mismatches = mismatches + 1;
      end else begin
        want = variance_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: scaled_variance mismatch: expected %h, actual %h",
                   $time, want, m_axis_tdata);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    step_t st;
    int    len;
    len_reg   = lnvar_pkg::ROW_LENGTH_RST;
    eps_reg   = lnvar_pkg::EPS_VALUE_RST;
    gain_reg  = lnvar_pkg::VARIANCE_GAIN_RST;
    acc_count = 0;
    acc_sum   = 0;
    acc_sumsq = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Single-sample rows at the extremes: variance is zero
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'd1, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h7FFF, 1'b1, 48'd0);
    add_step(STEP_SAMPLE, '0, 32'h8000, 1'b1, 48'd0);
    // Zero length behaves as one
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'd0, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h0001, 1'b1, 48'd0);
    add_step(STEP_SAMPLE, '0, 32'hFFFF, 1'b1, 48'd0);
    // Epsilon alone, then the gain extremes
    add_step(STEP_WRITE,  lnvar_pkg::REG_EPS_VALUE, 32'hFFFF_FFFF, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h1234, 1'b1, 48'h0000_FFFF_FFFF);
    add_step(STEP_WRITE,  lnvar_pkg::REG_VARIANCE_GAIN, 32'h0000_FFFF, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h0000, 1'b0, '0);
    add_step(STEP_WRITE,  lnvar_pkg::REG_VARIANCE_GAIN, 32'd0, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h8000, 1'b1, 48'd0);
    add_step(STEP_WRITE,  lnvar_pkg::REG_EPS_VALUE, 32'd0, 1'b0, '0);
    add_step(STEP_WRITE,  lnvar_pkg::REG_VARIANCE_GAIN, 32'h0000_1000, 1'b0, '0);
    // Two-sample rows: 1.0 and 3.0 give a variance of exactly 1.0
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'd2, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h1000, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h3000, 1'b1, 48'h00_0001_000000);
    add_step(STEP_SAMPLE, '0, 32'h7FFF, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h8000, 1'b0, '0);
    // Length shortened mid-row; a write to the spare index changes nothing
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'd8, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h0800, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'hF800, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h7FFF, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h8000, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h0123, 1'b0, '0);
    add_step(STEP_WRITE,  REG_SPARE, 32'hFFFF_FFFF, 1'b0, '0);
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'd3, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h4000, 1'b0, '0);
    // Upper data bits are ignored for the length register
    add_step(STEP_WRITE,  lnvar_pkg::REG_ROW_LENGTH, 32'hFFFF_F801, 1'b0, '0);
    add_step(STEP_SAMPLE, '0, 32'h5A5A, 1'b1, 48'd0);

    foreach (directed[i]) begin
      st = directed[i];
      gaps_on = $urandom_range(0, 1);
      if (st.kind == STEP_WRITE)
        write_register(st.idx, st.data);
      else
        offer(st.data[lnvar_pkg::SAMPLE_W-1:0], st.has_typed, st.typed);
    end

    // One full-size row; lengths above the limit clamp to it
    set_phase_registers($urandom_range(ROW_MAX, 2047));
    send_samples(ROW_MAX + 5);

    // Short rows while the receiver holds off, so the input stalls
    set_phase_registers(2);
    hold_off_req = 1'b1;
    gaps_on      = 1'b0;
    repeat (120) offer(16'($urandom), 1'b0, '0);

    // Mostly short rows, lengths changing with partial rows carried over
    while (samples_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:          len = 0;
        1:          len = 1;
        2, 3, 4, 5: len = $urandom_range(2, 12);
        6, 7, 8:    len = $urandom_range(13, 64);
        default:    len = $urandom_range(65, 200);
      endcase
      set_phase_registers(len);
      send_samples($urandom_range(1, 40));
    end

    wait_idle();
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* layernorm_row_variance_stats.f */
rtl/lnvar_pkg.sv
rtl/lnvar_front.sv
rtl/lnvar_queue.sv
rtl/lnvar_back.sv
rtl/layernorm_row_variance_stats.sv
tb/layernorm_row_variance_stats_tb.sv
